>>> sv/s256_pkg.sv
package s256_pkg;

    // Eight 32-bit words; element 0 is a, element 7 is h
    typedef logic [7:0][31:0] hash_t;

    // Sixteen-word schedule window; element 15 holds the oldest word
    typedef logic [15:0][31:0] sched_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } state_t;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_POS     = 56;
    localparam logic [7:0]  PAD_MARK    = 8'h80;

    localparam hash_t HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Round constants
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

>>> sv/s256_round.sv
module s256_round (
    input  s256_pkg::hash_t  work,
    input  s256_pkg::sched_t win,
    input  logic [5:0]       rnd,
    output s256_pkg::hash_t  work_next,
    output logic [31:0]      w_next
);
    import s256_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

    logic [31:0] w_cur;
    logic [31:0] big_s1;
    logic [31:0] big_s0;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] g0;
    logic [31:0] g1;

    // One compression round on a..h
    always_comb
    begin
        w_cur  = win[15];
        big_s1 = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
        ch     = (work[4] & work[5]) ^ (~work[4] & work[6]);
        t1     = work[7] + big_s1 + ch + round_k(rnd) + w_cur;
        big_s0 = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
        maj    = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
        t2     = big_s0 + maj;

        work_next[0] = t1 + t2;
        work_next[1] = work[0];
        work_next[2] = work[1];
        work_next[3] = work[2];
        work_next[4] = work[3] + t1;
        work_next[5] = work[4];
        work_next[6] = work[5];
        work_next[7] = work[6];
    end

    // Extend the schedule by one word, sixteen ahead of the current one
    always_comb
    begin
        g0     = rotr(win[14], 7) ^ rotr(win[14], 18) ^ (win[14] >> 3);
        g1     = rotr(win[1], 17) ^ rotr(win[1], 19) ^ (win[1] >> 10);
        w_next = g1 + win[6] + g0 + win[15];
    end

endmodule

>>> sv/sha256_stream_hasher.sv
// SHA-256 over a byte stream. Each input transaction carries at most one message
// byte (s_tuser[0] marks it as present) and s_tlast closes the message. Message
// bytes are taken one per cycle while the block is idle; every 64th byte makes the
// block busy for 64 rounds on the single shared round unit and a fold into the
// chaining words. On s_tlast the padding bytes are shifted into the same block
// buffer one per cycle (64 minus the fill level, plus 64 more when the fill level
// is 56 or above), each padded block goes through the rounds and the fold again,
// and the digest then leaves as four 64-bit big-endian words. s_tready is low
// for all of that time. An end transaction without a byte is legal and gives the
// digest of whatever came before, including the empty message.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_word
    output logic [1:0]  m_tuser,   // [1:0] word_index
    output logic        m_tlast    // last_word
);
    import s256_pkg::*;

    state_t       state_reg, state_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  count_reg, count_next;
    hash_t        chain_reg, chain_next;
    hash_t        work_reg, work_next;
    sched_t       win_reg, win_next;
    logic         pad_active_reg, pad_active_next;
    logic         pad_first_reg, pad_first_next;
    logic         len_ok_reg, len_ok_next;
    logic         end_pending_reg, end_pending_next;
    logic [1:0]   word_reg, word_next;

    hash_t        rnd_work;
    logic [31:0]  rnd_w;
    logic [511:0] win_flat;
    logic [63:0]  len_shift;
    logic [7:0]   pad_byte;

    s256_round u_round (
        .work      (work_reg),
        .win       (win_reg),
        .rnd       (rnd_reg),
        .work_next (rnd_work),
        .w_next    (rnd_w)
    );

    assign win_flat = win_reg;

    // Pick the next padding byte: marker, zero fill or big-endian bit length
    always_comb
    begin
        len_shift = {count_reg, 3'b000} << {fill_reg[2:0], 3'b000};
        if (pad_first_reg)
            pad_byte = PAD_MARK;
        else if (len_ok_reg && (fill_reg >= 6'(LEN_POS)))
            pad_byte = len_shift[63:56];
        else
            pad_byte = 8'h00;
    end

    // Sequence byte intake, rounds, padding and digest output
    always_comb
    begin
        state_next       = state_reg;
        rnd_next         = rnd_reg;
        fill_next        = fill_reg;
        count_next       = count_reg;
        chain_next       = chain_reg;
        work_next        = work_reg;
        win_next         = win_reg;
        pad_active_next  = pad_active_reg;
        pad_first_next   = pad_first_reg;
        len_ok_next      = len_ok_reg;
        end_pending_next = end_pending_reg;
        word_next        = word_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0])
                    begin
                        win_next   = {win_flat[503:0], s_tdata};
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                    end
                    if (s_tuser[0] && (fill_reg == 6'(BLOCK_BYTES - 1)))
                    begin
                        state_next       = ST_ROUND;
                        work_next        = chain_reg;
                        rnd_next         = '0;
                        end_pending_next = s_tlast;
                    end
                    else if (s_tlast)
                    begin
                        state_next      = ST_PAD;
                        pad_active_next = 1'b1;
                        pad_first_next  = 1'b1;
                        len_ok_next     = (fill_next < 6'(LEN_POS));
                    end
                end
            end
            ST_ROUND:
            begin
                work_next = rnd_work;
                win_next  = {win_reg[14:0], rnd_w};
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'(BLOCK_BYTES - 1))
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                for (int i = 0; i < 8; i++)
                    chain_next[i] = chain_reg[i] + work_reg[i];
                if (pad_active_reg)
                begin
                    if (len_ok_reg)
                    begin
                        state_next = ST_OUT;
                        word_next  = '0;
                    end
                    else
                    begin
                        len_ok_next = 1'b1;
                        state_next  = ST_PAD;
                    end
                end
                else if (end_pending_reg)
                begin
                    end_pending_next = 1'b0;
                    pad_active_next  = 1'b1;
                    pad_first_next   = 1'b1;
                    len_ok_next      = 1'b1;
                    state_next       = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                win_next       = {win_flat[503:0], pad_byte};
                fill_next      = fill_reg + 6'd1;
                pad_first_next = 1'b0;
                if (fill_reg == 6'(BLOCK_BYTES - 1))
                begin
                    state_next = ST_ROUND;
                    work_next  = chain_reg;
                    rnd_next   = '0;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    word_next = word_reg + 2'd1;
                    if (word_reg == 2'd3)
                    begin
                        chain_next      = HASH_IV;
                        count_next      = '0;
                        pad_active_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rnd_reg         <= '0;
            fill_reg        <= '0;
            count_reg       <= '0;
            chain_reg       <= HASH_IV;
            pad_active_reg  <= 1'b0;
            pad_first_reg   <= 1'b0;
            len_ok_reg      <= 1'b0;
            end_pending_reg <= 1'b0;
            word_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rnd_reg         <= rnd_next;
            fill_reg        <= fill_next;
            count_reg       <= count_next;
            chain_reg       <= chain_next;
            pad_active_reg  <= pad_active_next;
            pad_first_reg   <= pad_first_next;
            len_ok_reg      <= len_ok_next;
            end_pending_reg <= end_pending_next;
            word_reg        <= word_next;
        end
    end

    // Advance the block buffer and round variables
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

    // Drive the stream ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {chain_reg[{word_reg, 1'b0}], chain_reg[{word_reg, 1'b1}]};
    assign m_tuser  = word_reg;
    assign m_tlast  = (word_reg == 2'd3);

    // Never take input while a digest is on offer
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input and output handshakes open together");

    // The last digest word returns the block to byte intake
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("block not idle after last digest word");

    // The final round hands over to the chaining update
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (rnd_reg == 6'd63) |=> (state_reg == ST_FINAL))
        else $error("round sequence overran");

    // Padding always ends on a block boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (fill_reg == 6'd0))
        else $error("digest offered with a partly filled block");

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One digest word as it leaves the block
    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  idx;
        logic        last;
    } digest_beat_t;

    // One directed stimulus row; dig is used only where known is set
    typedef struct packed {
        logic [7:0]   b;
        logic         v;
        logic         e;
        logic         known;
        logic [255:0] dig;
    } stim_row_t;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam int N_DIR = 13;
    localparam stim_row_t DIR_ROWS [N_DIR] = '{
        '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},           // idle with junk byte
        '{8'ha5, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},     // empty message, byte ignored
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},       // "abc", last byte on end item
        '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h5a, 1'b0, 1'b1, 1'b0, 256'h0},           // end item with no byte
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h3c, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}      // back to the initial values
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam int CORNER_LENS [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Hash model state
    logic [7:0]  blk_bytes [64];
    logic [31:0] chain_h [8];
    logic [60:0] msg_len;

    digest_beat_t pending_digest_q [$];

    bit gaps_on = 1'b0;
    int stall_left = 0;
    int error_count = 0;
    int items_sent = 0;
    int bytes_sent = 0;
    int msgs_done = 0;
    int words_checked = 0;

    sha256_stream_hasher u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // Give up well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Compress the buffered block into the chaining words
    function automatic void fold_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        end
        for (int t = 16; t < 64; t++)
        begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        v = chain_h;
        for (int t = 0; t < 64; t++)
        begin
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            chain_h[i] = chain_h[i] + v[i];
        end
    endfunction

    // Absorb one accepted transaction; on the end marker pad, finish and queue the digest
    function automatic void sha_absorb(input logic [7:0] b, input logic v, input logic e);
        logic [5:0]   fill;
        logic [63:0]  bit_len;
        digest_beat_t beat;
        if (v)
        begin
            blk_bytes[msg_len[5:0]] = b;
            msg_len = msg_len + 61'd1;
            if (msg_len[5:0] == 6'd0)
                fold_block();
        end
        if (e)
        begin
            fill = msg_len[5:0];
            blk_bytes[fill] = 8'h80;
            for (int i = int'(fill) + 1; i < 64; i++)
                blk_bytes[i] = 8'h00;
            // no room left for the length: spill into a second block
            if (fill >= 6'd56)
            begin
                fold_block();
                for (int i = 0; i < 56; i++)
                    blk_bytes[i] = 8'h00;
            end
            bit_len = {msg_len, 3'b000};
            for (int i = 0; i < 8; i++)
                blk_bytes[63-i] = bit_len[8*i +: 8];
            fold_block();
            for (int k = 0; k < 4; k++)
            begin
                beat.word = {chain_h[2*k], chain_h[2*k+1]};
                beat.idx  = 2'(k);
                beat.last = (k == 3);
                pending_digest_q.insert(pending_digest_q.size(), beat);
            end
            chain_h = SHA_IV;
            msg_len = '0;
            msgs_done++;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Present one transaction at a falling edge and hold it until accepted
    task automatic drive_item(input logic [7:0] b, input logic v, input logic e,
                              input logic known, input logic [255:0] dig);
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 11);
            repeat (n) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= v;
        s_tlast  <= e;
        do
            @(posedge clk);
        while (!s_tready);
        sha_absorb(b, v, e);
        if (v || e)
            items_sent++;
        if (v)
            bytes_sent++;
        // substitute the hand-typed digest for a well-known message
        if (known)
        begin
            n = pending_digest_q.size();
            for (int k = 0; k < 4; k++)
                pending_digest_q[n-4+k].word = dig[255-64*k -: 64];
        end
        @(negedge clk);
    endtask

    // Hold the sender off until every queued digest word has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_digest_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare each digest transaction with the oldest expectation
    always @(posedge clk)
    begin : digest_check
        digest_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digest_q.size() == 0)
            begin
                report_mismatch("unexpected digest word", m_tdata, 64'h0);
            end
            else
            begin
                want = pending_digest_q.pop_front();
                if (m_tdata !== want.word)
                    report_mismatch("digest_word", m_tdata, want.word);
                if (m_tuser !== want.idx)
                    report_mismatch("word_index", 64'(m_tuser), 64'(want.idx));
                if (m_tlast !== want.last)
                    report_mismatch("last_word", 64'(m_tlast), 64'(want.last));
                words_checked++;
            end
        end
    end

    initial
    begin : stimulus
        int len;
        bit sep_end;
        logic [7:0] b;
        chain_h = SHA_IV;
        msg_len = '0;
        for (int i = 0; i < 64; i++)
            blk_bytes[i] = 8'h00;

        // Hold reset, release on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows
        gaps_on = 1'b1;
        for (int r = 0; r < N_DIR; r++)
            drive_item(DIR_ROWS[r].b, DIR_ROWS[r].v, DIR_ROWS[r].e,
                       DIR_ROWS[r].known, DIR_ROWS[r].dig);
        wait_drained();

        // Random messages, lengths biased toward padding boundaries
        while (items_sent < 380)
        begin
            if ($urandom_range(0, 9) < 3)
                len = CORNER_LENS[$urandom_range(0, 11)];
            else
                len = $urandom_range(1, 70);
            // no new random gaps or stalls in the last stretch
            if (items_sent > 320)
                gaps_on = 1'b0;
            else
                gaps_on = ($urandom_range(0, 4) != 0);
            sep_end = (len == 0) || ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                b = 8'($urandom_range(0, 255));
                drive_item(b, 1'b1, !sep_end && (i == len - 1), 1'b0, '0);
            end
            if (sep_end)
                drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        s_tvalid <= 1'b0;

        // Let the last digest drain, then a short settle
        while (pending_digest_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Hashed %0d messages (%0d message bytes, %0d accepted items);",
                 msgs_done, bytes_sent, items_sent);
        $display("checked %0d digest words, %0d mismatches.", words_checked, error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sha256_stream_hasher.f
sv/s256_pkg.sv
sv/s256_round.sv
sv/sha256_stream_hasher.sv
tb/tb.sv
